>>> design/dnv_pkg.sv
// ----------------------------------------------------------------------------
// Dataset name validator package
// Shared types and character codes for the name validator.
// ----------------------------------------------------------------------------
package dnv_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_LEAD_DOT  = 3'd2,
    ST_TWO_DOTS  = 3'd3,
    ST_END_DOT   = 3'd4,
    ST_FEW_QUALS = 3'd5,
    ST_TOO_LONG  = 3'd6,
    ST_QUAL_LONG = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAX_NAME_LEN = 2'd0,
    CFG_MAX_QUAL_LEN = 2'd1,
    CFG_MIN_QUAL_CNT = 2'd2
  } cfg_index_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_HYPHEN  = 8'h2D;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam logic [7:0] RST_MAX_NAME_LEN = 8'd44;
  localparam logic [3:0] RST_MAX_QUAL_LEN = 4'd8;
  localparam logic [7:0] RST_MIN_QUAL_CNT = 8'd2;

  typedef struct packed {
    logic terminator;
    logic letter;
    logic follow;
    logic dot;
  } char_class_t;

  typedef struct packed {
    logic [7:0] name_length;
    status_t    status;
  } result_t;

endpackage

>>> design/dataset_name_validator_core.sv
// ----------------------------------------------------------------------------
// Dataset name validator core
// Checks dotted names that arrive one character per word, ended by a zero.
// ----------------------------------------------------------------------------
// Each word on the slave stream carries one character of a name; a zero byte
// ends the name. For every terminator the master stream carries one status
// word with the status code and the number of characters before the
// terminator. Other characters produce no output word.
// The block takes one word per cycle unless a terminator waits for the
// output register. A word is held in an input register, then the tracker
// updates its counters and, on a terminator, loads the output register, so a
// status word passes the input register and then the output register. When
// the receiver stalls the status word stays in the output register; ordinary
// characters still flow and only a second terminator waits. Reset clears all
// name state, empties both registers and loads the default limits (name 44,
// qualifier 8, at least two qualifiers). Configuration writes take effect
// from the next character and should be made only between names.
// ----------------------------------------------------------------------------
module dataset_name_validator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] status, [10:3] name_length, [15:11] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic [7:0] max_name_length;
  logic [3:0] max_qualifier_length;
  logic [7:0] min_qualifier_count;
  logic       out_free;
  logic       advance;

  dnv_pkg::char_class_t char_class;
  dnv_pkg::result_t     result;
  dnv_pkg::result_t     out_result;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!char_class.terminator || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length      <= dnv_pkg::RST_MAX_NAME_LEN;
      max_qualifier_length <= dnv_pkg::RST_MAX_QUAL_LEN;
      min_qualifier_count  <= dnv_pkg::RST_MIN_QUAL_CNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dnv_pkg::CFG_MAX_NAME_LEN: max_name_length      <= cfg_data;
        dnv_pkg::CFG_MAX_QUAL_LEN: max_qualifier_length <= cfg_data[3:0];
        dnv_pkg::CFG_MIN_QUAL_CNT: min_qualifier_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  dnv_class u_class (
    .char_byte  (in_byte),
    .char_class (char_class)
  );

  dnv_track u_track (
    .clk                  (clk),
    .rst                  (rst),
    .step                 (advance),
    .char_class           (char_class),
    .max_name_length      (max_name_length),
    .max_qualifier_length (max_qualifier_length),
    .min_qualifier_count  (min_qualifier_count),
    .result               (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && char_class.terminator;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && char_class.terminator) begin
      out_result <= result;
    end
  end

  assign m_tdata = {5'd0, out_result.name_length, out_result.status};

  a_term_gives_word: assert property (@(posedge clk) disable iff (rst)
    (advance && char_class.terminator) |=> m_tvalid)
    else $error("terminator processed without a status word");

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_byte)))
    else $error("stalled character lost or changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("empty input register refused a word");

  a_stall_only_term: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> (char_class.terminator && m_tvalid && !m_tready))
    else $error("input stalled without a blocked terminator");

endmodule

>>> design/dnv_class.sv
// ----------------------------------------------------------------------------
// Character classifier
// Sorts one name byte into terminator, letter-like, digit or hyphen, and dot.
// ----------------------------------------------------------------------------
module dnv_class (
  input  logic [7:0]          char_byte,
  output dnv_pkg::char_class_t char_class
);

  always_comb begin
    char_class.terminator = (char_byte == dnv_pkg::CH_NUL);
    char_class.letter =
        (char_byte >= dnv_pkg::CH_LOWER_A && char_byte <= dnv_pkg::CH_LOWER_Z) ||
        (char_byte >= dnv_pkg::CH_UPPER_A && char_byte <= dnv_pkg::CH_UPPER_Z) ||
        (char_byte == dnv_pkg::CH_DOLLAR) || (char_byte == dnv_pkg::CH_HASH) ||
        (char_byte == dnv_pkg::CH_AT);
    char_class.follow =
        (char_byte >= dnv_pkg::CH_DIGIT_0 && char_byte <= dnv_pkg::CH_DIGIT_9) ||
        (char_byte == dnv_pkg::CH_HYPHEN);
    char_class.dot = (char_byte == dnv_pkg::CH_DOT);
  end

endmodule

>>> design/dnv_track.sv
// ----------------------------------------------------------------------------
// Name state tracker
// Holds the per-name counters and sticky error, and forms the status word
// when the terminator arrives.
// ----------------------------------------------------------------------------
module dnv_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  dnv_pkg::char_class_t char_class,
  input  logic [7:0]           max_name_length,
  input  logic [3:0]           max_qualifier_length,
  input  logic [7:0]           min_qualifier_count,
  output dnv_pkg::result_t     result
);

  logic [3:0]       qualifier_length;
  logic [7:0]       qualifier_count;
  logic [7:0]       position;
  dnv_pkg::status_t first_error;

  logic [3:0]       qualifier_length_next;
  logic [7:0]       qualifier_count_next;
  logic [7:0]       position_next;
  dnv_pkg::status_t first_error_next;
  logic [3:0]       grown_length;

  always_comb begin
    grown_length = (qualifier_length == 4'hF) ? qualifier_length : qualifier_length + 4'd1;
    qualifier_length_next = qualifier_length;
    qualifier_count_next  = qualifier_count;
    first_error_next      = first_error;
    position_next         = (position == 8'hFF) ? position : position + 8'd1;

    result.name_length = position;
    result.status      = first_error;
    if (first_error == dnv_pkg::ST_OK) begin
      if (qualifier_length == 4'd0) begin
        result.status = dnv_pkg::ST_END_DOT;
      end else if (qualifier_count < min_qualifier_count) begin
        result.status = dnv_pkg::ST_FEW_QUALS;
      end else if (position > max_name_length) begin
        result.status = dnv_pkg::ST_TOO_LONG;
      end
    end

    if (char_class.terminator) begin
      qualifier_length_next = 4'd0;
      qualifier_count_next  = 8'd1;
      position_next         = 8'd0;
      first_error_next      = dnv_pkg::ST_OK;
    end else if (first_error == dnv_pkg::ST_OK) begin
      if (char_class.letter) begin
        qualifier_length_next = grown_length;
      end else if (char_class.follow) begin
        if (qualifier_length == 4'd0) begin
          first_error_next = dnv_pkg::ST_BAD_START;
        end else begin
          qualifier_length_next = grown_length;
        end
      end else if (char_class.dot) begin
        if (qualifier_length == 4'd0) begin
          first_error_next = (position == 8'd0) ? dnv_pkg::ST_LEAD_DOT
                                                : dnv_pkg::ST_TWO_DOTS;
        end else begin
          qualifier_length_next = 4'd0;
          if (qualifier_count != 8'hFF) begin
            qualifier_count_next = qualifier_count + 8'd1;
          end
        end
      end
      if (first_error_next == dnv_pkg::ST_OK &&
          qualifier_length_next > max_qualifier_length) begin
        first_error_next = dnv_pkg::ST_QUAL_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qualifier_length <= 4'd0;
      qualifier_count  <= 8'd1;
      position         <= 8'd0;
      first_error      <= dnv_pkg::ST_OK;
    end else if (step) begin
      qualifier_length <= qualifier_length_next;
      qualifier_count  <= qualifier_count_next;
      position         <= position_next;
      first_error      <= first_error_next;
    end
  end

endmodule
